@@ rtl/base58_key_decoder_unit_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the Base58 key decoder
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef BASE58_KEY_DECODER_UNIT_MACROS_SVH
`define BASE58_KEY_DECODER_UNIT_MACROS_SVH

// Same-cycle implication.
`define B58KD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("base58 key decoder: assertion failed");

// Next-cycle implication.
`define B58KD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("base58 key decoder: assertion failed");

`endif

@@ rtl/b58kd_pkg.sv @@
// ---------------------------------------------------------------------------
// Base58 key decoder package
// Types, constants and the digit decode function of the decoder.
// ---------------------------------------------------------------------------
package b58kd_pkg;

  localparam int ACC_W     = 256;
  localparam int WORD_W    = 64;
  localparam int KEY_WORDS = 4;
  localparam int PROD_W    = ACC_W + 6;

  localparam logic [1:0] LAST_IDX = 2'(KEY_WORDS - 1);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] value;
  } digit_t;

  typedef struct packed {
    logic               load;
    status_t            status;
    logic [ACC_W-1:0]   key;
  } done_t;

  // Bitcoin alphabet: 1-9, A-H, J-N, P-Z, a-k, m-z.
  function automatic digit_t digit_of(input logic [7:0] code);
    digit_t d;
    d.ok    = 1'b1;
    d.value = 6'd0;
    if (code >= 8'h31 && code <= 8'h39) begin
      d.value = 6'(code - 8'h31);
    end else if (code >= 8'h41 && code <= 8'h48) begin
      d.value = 6'(code - 8'h41 + 8'd9);
    end else if (code >= 8'h4a && code <= 8'h4e) begin
      d.value = 6'(code - 8'h4a + 8'd17);
    end else if (code >= 8'h50 && code <= 8'h5a) begin
      d.value = 6'(code - 8'h50 + 8'd22);
    end else if (code >= 8'h61 && code <= 8'h6b) begin
      d.value = 6'(code - 8'h61 + 8'd33);
    end else if (code >= 8'h6d && code <= 8'h7a) begin
      d.value = 6'(code - 8'h6d + 8'd44);
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

endpackage

@@ rtl/b58kd_if.sv @@
// ---------------------------------------------------------------------------
// Base58 key decoder channel interfaces
// Valid/ready channels for input characters and decoded key results.
// ---------------------------------------------------------------------------
interface b58kd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       no_char;
  logic       end_of_text;

  modport source (output valid, output char_code, output no_char, output end_of_text,
                  input ready);
  modport sink (input valid, input char_code, input no_char, input end_of_text,
                output ready);
endinterface

interface b58kd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [1:0]  word_index;
  logic [63:0] key_word;
  logic        last_word;

  modport source (output valid, output status, output word_index, output key_word,
                  output last_word, input ready);
  modport sink (input valid, input status, input word_index, input key_word,
                input last_word, output ready);
endinterface

@@ rtl/b58kd_accum.sv @@
// ---------------------------------------------------------------------------
// Base58 key decoder accumulator
// Input register, digit decode, multiply by 58 and add, sticky error flags.
// ---------------------------------------------------------------------------
module b58kd_accum
  import b58kd_pkg::*;
#(
  parameter int KEY_BYTES = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  b58kd_in_if.sink      in_ch,
  input  logic          seq_free,
  output done_t         done
);

  localparam int LIMIT_BYTES = (KEY_BYTES > ACC_W / 8) ? ACC_W / 8 : KEY_BYTES;
  localparam int LIMIT_BITS  = LIMIT_BYTES * 8;
  localparam logic [ACC_W-1:0] LIMIT_MASK = {ACC_W{1'b1}} >> (ACC_W - LIMIT_BITS);

  logic              in_valid_r;
  logic [7:0]        char_r;
  logic              none_r;
  logic              last_r;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic              bad_r, bad_nxt;
  logic              ovf_r, ovf_nxt;
  logic              any_r, any_nxt;

  digit_t            dig;
  logic              take;
  logic              proceed;
  logic [PROD_W-1:0] acc_ext;
  logic [PROD_W-1:0] prod;
  logic              ovf_hit;
  logic [ACC_W-1:0]  acc_step;
  logic              bad_step, ovf_step, any_step;
  status_t           status_step;

  assign proceed     = in_valid_r && (!last_r || seq_free);
  assign in_ch.ready = !in_valid_r || proceed;

  always_comb begin
    dig     = digit_of(char_r);
    take    = !none_r && dig.ok && !bad_r;
    acc_ext = {6'd0, acc_r};
    // 58 = 64 - 4 - 2
    prod    = (acc_ext << 6) - (acc_ext << 2) - (acc_ext << 1) + PROD_W'(dig.value);
    ovf_hit = (|prod[PROD_W-1:ACC_W]) || (|(prod[ACC_W-1:0] & ~LIMIT_MASK));

    acc_step = take ? prod[ACC_W-1:0] : acc_r;
    bad_step = bad_r || (!none_r && !dig.ok);
    any_step = any_r || !none_r;
    ovf_step = ovf_r || (take && ovf_hit);

    if (!any_step) begin
      status_step = ST_EMPTY;
    end else if (bad_step) begin
      status_step = ST_BAD_CHAR;
    end else if (ovf_step) begin
      status_step = ST_OVERFLOW;
    end else begin
      status_step = ST_OK;
    end

    acc_nxt = acc_r;
    bad_nxt = bad_r;
    ovf_nxt = ovf_r;
    any_nxt = any_r;
    if (proceed) begin
      if (last_r) begin
        acc_nxt = '0;
        bad_nxt = 1'b0;
        ovf_nxt = 1'b0;
        any_nxt = 1'b0;
      end else begin
        acc_nxt = acc_step;
        bad_nxt = bad_step;
        ovf_nxt = ovf_step;
        any_nxt = any_step;
      end
    end

    done.load   = proceed && last_r;
    done.status = status_step;
    done.key    = (status_step == ST_OK) ? acc_step : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      acc_r      <= '0;
      bad_r      <= 1'b0;
      ovf_r      <= 1'b0;
      any_r      <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      acc_r <= acc_nxt;
      bad_r <= bad_nxt;
      ovf_r <= ovf_nxt;
      any_r <= any_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      char_r <= in_ch.char_code;
      none_r <= in_ch.no_char;
      last_r <= in_ch.end_of_text;
    end
  end

endmodule

@@ rtl/b58kd_out_seq.sv @@
// ---------------------------------------------------------------------------
// Base58 key decoder result sequencer
// Holds a finished key or error and sends it out one 64-bit word at a time.
// ---------------------------------------------------------------------------
`include "base58_key_decoder_unit_macros.svh"

module b58kd_out_seq
  import b58kd_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  done_t         done,
  output logic          seq_free,
  b58kd_out_if.source   out_ch
);

  logic              out_valid_r;
  status_t           status_r;
  logic [1:0]        idx_r;
  logic [WORD_W-1:0] key_r [KEY_WORDS];
  logic              is_last;
  logic              xfer;

  assign is_last  = (status_r != ST_OK) || (idx_r == LAST_IDX);
  assign xfer     = out_valid_r && out_ch.ready;
  assign seq_free = !out_valid_r || (xfer && is_last);

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = status_r;
  assign out_ch.word_index = idx_r;
  assign out_ch.key_word   = key_r[idx_r];
  assign out_ch.last_word  = is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
      status_r    <= ST_OK;
    end else if (done.load) begin
      out_valid_r <= 1'b1;
      idx_r       <= 2'd0;
      status_r    <= done.status;
    end else if (xfer) begin
      if (is_last) begin
        out_valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done.load) begin
      for (int i = 0; i < KEY_WORDS; i++) begin
        key_r[i] <= done.key[(KEY_WORDS - 1 - i) * WORD_W +: WORD_W];
      end
    end
  end

  `B58KD_ASSERT_NOW(a_load_only_when_free, done.load, seq_free)
  `B58KD_ASSERT_NOW(a_error_single_word, out_valid_r && status_r != ST_OK,
                    idx_r == 2'd0 && is_last && out_ch.key_word == '0)
  `B58KD_ASSERT_NEXT(a_word_advance, xfer && !is_last && !done.load,
                     out_valid_r && idx_r == 2'($past(idx_r) + 2'd1))

endmodule

@@ rtl/base58_key_decoder_unit.sv @@
// ---------------------------------------------------------------------------
// Base58 key decoder
// Decodes Bitcoin-alphabet Base58 text into a 256-bit key in 64-bit words.
// ---------------------------------------------------------------------------
// The input channel carries one character per transfer, with no_char for an
// item without a character and end_of_text on the final item of a text.
// Each character is registered, then multiplied into a 256-bit accumulator
// by 58 plus its digit value in the following cycle, so one character is
// taken every cycle while no final item waits.
// The final item yields four result transfers, word 0 most significant, or a
// single error transfer with a zero key word. The first result is offered
// from the output register, and words follow one a cycle while ready is high.
// The single output register holds one finished text. While it still has
// words to send, characters of the next text keep flowing; only the next
// final item waits in the input register, and the input stalls behind it.
// A receiver stall simply holds the current word.
// Synchronous reset empties both registers and clears the accumulator and
// the error flags.
// ---------------------------------------------------------------------------
module base58_key_decoder_unit
  import b58kd_pkg::*;
#(
  parameter int KEY_BYTES = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  b58kd_in_if.sink      in_ch,
  b58kd_out_if.source   out_ch
);

  done_t done;
  logic  seq_free;

  b58kd_accum #(
    .KEY_BYTES (KEY_BYTES)
  ) u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .seq_free (seq_free),
    .done     (done)
  );

  b58kd_out_seq u_out_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .done     (done),
    .seq_free (seq_free),
    .out_ch   (out_ch)
  );

endmodule
